// File: hdl/pkmer_pkg.sv
// ----------------------------------------------------------------------------
// pkmer_pkg: shared types and constants of the profile most probable k-mer scan
// Field widths, fixed-point constants, operation codes and the control bundle
// that the top level hands to each scoring cell.
// ----------------------------------------------------------------------------
package pkmer_pkg;

    localparam int NUC_W          = 2;
    localparam int COL_W          = 4;
    localparam int PROB_W         = 17;
    localparam int PROB_FRAC_BITS = 16;
    localparam int SCORE_W        = 33;
    localparam int START_W        = 20;
    localparam int BASES_W        = 32;
    localparam int CFG_W          = 5;
    localparam int PP_SLOTS       = 16;
    localparam int NUC_CODES      = 4;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 88;

    localparam logic [PROB_W-1:0]  PROB_ONE  = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [SCORE_W-1:0] SCORE_ONE = SCORE_W'(1) << (SCORE_W - 1);
    localparam logic [CFG_W-1:0]   WINDOW_LENGTH_RESET = CFG_W'(1);

    typedef enum logic {
        OP_PROFILE_WRITE = 1'b0,
        OP_BASE          = 1'b1
    } op_t;

    typedef struct packed {
        logic              wr_en;
        logic              shift_en;
        logic              clear;
        logic [NUC_W-1:0]  nuc;
        logic [PROB_W-1:0] prob;
    } cell_ctrl_t;

endpackage

// File: hdl/pkmer_cell.sv
// ----------------------------------------------------------------------------
// pkmer_cell: one window position of the scoring chain
// Holds the four profile entries of its column and the partial product of the
// window that has received as many bases as its place in the chain. On each
// base it scales the product handed over by its left neighbor.
// ----------------------------------------------------------------------------
module pkmer_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pkmer_pkg::cell_ctrl_t               ctrl,
    input  logic [pkmer_pkg::SCORE_W-1:0]       prev_pp,
    output logic [pkmer_pkg::SCORE_W-1:0]       pp
);
    import pkmer_pkg::*;

    localparam int PROD_W = SCORE_W + PROB_W;

    logic [PROB_W-1:0]  prob_reg [NUC_CODES];
    logic [SCORE_W-1:0] pp_reg;
    logic [SCORE_W-1:0] pp_next;
    logic [PROD_W-1:0]  product;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            prob_reg[ctrl.nuc] <= ctrl.prob;
        end
    end

    // Truncating Q1.32 by Q1.16 multiply; both operands are at most one.
    always_comb begin
        product = PROD_W'(prev_pp) * PROD_W'(prob_reg[ctrl.nuc]);
        pp_next = pp_reg;
        if (ctrl.clear) begin
            pp_next = '0;
        end else if (ctrl.shift_en) begin
            pp_next = product[PROB_FRAC_BITS +: SCORE_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg <= '0;
        end else begin
            pp_reg <= pp_next;
        end
    end

    assign pp = pp_reg;

endmodule

// File: hdl/profile_most_probable_kmer_scan_unit.sv
// ----------------------------------------------------------------------------
// profile_most_probable_kmer_scan_unit: profile most probable k-mer scanner
// Loads a 4-by-k probability profile, scans a base stream through a chain of
// scoring cells and reports the earliest highest scoring window per sequence.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  s_      | in        | tdata: nucleotide, profile_column, probability;
//          |           | tuser: operation; tlast: last_base
//  m_      | out       | tdata: best_start, best_bases, best_score; tuser: status
//  cfg_    | in        | window_length write, no read-back
//
//  The input accepts base and profile writes; all open windows advance at once
//  in the cell chain, and the best-window compare works on the registered
//  cell products. A base marked last holds the input while its compare finishes,
//  and longer if the result register is still waiting for m_tready.
//  Reset is synchronous and active low; the profile keeps no reset value.
// ----------------------------------------------------------------------------
module profile_most_probable_kmer_scan_unit #(
    parameter int MAX_WINDOW          = 16,
    parameter int MAX_SEQUENCE_LENGTH = 1048576
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [pkmer_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // nucleotide [1:0], profile_column [5:2], probability [22:6], zero [23]
    input  logic [pkmer_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation [0]
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // best_start [19:0], best_bases [51:20], best_score [84:52], zero [87:85]
    output logic [pkmer_pkg::M_TDATA_W-1:0]      m_tdata,
    // status [0]
    output logic                                 m_tuser
);
    import pkmer_pkg::*;

    localparam int NUM_CELLS = (MAX_WINDOW < PP_SLOTS) ? MAX_WINDOW : PP_SLOTS;
    localparam int KW        = $clog2(NUM_CELLS + 1);
    localparam int POS_W     = $clog2(MAX_SEQUENCE_LENGTH + 1);
    localparam int SHIFT_W   = $clog2(BASES_W + 1);

    // Input field unpacking.
    logic [NUC_W-1:0]  s_nuc;
    logic [COL_W-1:0]  s_col;
    logic [PROB_W-1:0] s_prob;
    logic [PROB_W-1:0] s_prob_sat;
    logic              s_fire;
    logic              s_is_base;
    logic              base_take;

    assign s_nuc      = s_tdata[NUC_W-1:0];
    assign s_col      = s_tdata[NUC_W +: COL_W];
    assign s_prob     = s_tdata[NUC_W + COL_W +: PROB_W];
    assign s_prob_sat = (s_prob > PROB_ONE) ? PROB_ONE : s_prob;

    logic [CFG_W-1:0]   wl_reg;
    logic [KW-1:0]      k_eff;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BASES_W-1:0] recent_reg, recent_next;
    logic [SCORE_W-1:0] top_score_reg, top_score_next;
    logic [START_W-1:0] top_start_reg, top_start_next;
    logic [BASES_W-1:0] top_bases_reg, top_bases_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic               cmp_took_reg, cmp_took_next;
    logic               cmp_last_reg, cmp_last_next;
    logic               m_valid_reg, m_valid_next;
    logic [START_W-1:0] m_start_reg, m_start_next;
    logic [BASES_W-1:0] m_bases_reg, m_bases_next;
    logic [SCORE_W-1:0] m_score_reg, m_score_next;
    logic               m_status_reg, m_status_next;

    logic               cmp_fire;
    logic               seq_clear;
    logic               pos_ge_k;
    logic               take;
    logic [SCORE_W-1:0] sel_score;
    logic [POS_W-1:0]   start_full;
    logic [START_W-1:0] cand_start;
    logic [SHIFT_W-1:0] bases_shift;
    logic [BASES_W-1:0] cand_bases;

    logic [SCORE_W-1:0] pp   [NUM_CELLS];
    cell_ctrl_t         ctrl [NUM_CELLS];

    // A zero window length acts as one, and a long one as the chain length.
    always_comb begin
        if (wl_reg == '0) begin
            k_eff = KW'(1);
        end else if (wl_reg > CFG_W'(NUM_CELLS)) begin
            k_eff = KW'(NUM_CELLS);
        end else begin
            k_eff = KW'(wl_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= WINDOW_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            wl_reg <= cfg_wr_data;
        end
    end

    // A last base waits in the compare stage until the result register frees.
    assign cmp_fire  = cmp_valid_reg && !(cmp_last_reg && m_valid_reg && !m_tready);
    assign seq_clear = cmp_fire && cmp_last_reg;
    assign s_tready  = !(cmp_valid_reg && cmp_last_reg);
    assign s_fire    = s_tvalid && s_tready;
    assign s_is_base = (op_t'(s_tuser) == OP_BASE);
    assign base_take = s_fire && s_is_base && (pos_reg < POS_W'(MAX_SEQUENCE_LENGTH));

    genvar j;
    generate
        for (j = 0; j < NUM_CELLS; j++) begin : g_cell
            logic [SCORE_W-1:0] prev_pp;

            if (j == 0) begin : g_head
                assign prev_pp = SCORE_ONE;
            end else begin : g_link
                assign prev_pp = pp[j-1];
            end

            always_comb begin
                ctrl[j].wr_en    = s_fire && !s_is_base && (s_col == COL_W'(j));
                ctrl[j].shift_en = base_take && (KW'(j) < k_eff);
                ctrl[j].clear    = seq_clear;
                ctrl[j].nuc      = s_nuc;
                ctrl[j].prob     = s_prob_sat;
            end

            pkmer_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl[j]),
                .prev_pp (prev_pp),
                .pp      (pp[j])
            );
        end
    endgenerate

    // Score of the window that just completed, taken from cell k-1.
    always_comb begin
        sel_score = '0;
        for (int i = 0; i < NUM_CELLS; i++) begin
            if (k_eff == KW'(i + 1)) begin
                sel_score = pp[i];
            end
        end
    end

    always_comb begin
        pos_ge_k    = (pos_reg >= POS_W'(k_eff));
        start_full  = pos_reg - POS_W'(k_eff);
        cand_start  = START_W'(start_full);
        bases_shift = SHIFT_W'(BASES_W) - (SHIFT_W'(k_eff) << 1);
        cand_bases  = recent_reg >> bases_shift;
        take        = cmp_took_reg && pos_ge_k &&
                      ((pos_reg == POS_W'(k_eff)) || (sel_score > top_score_reg));
    end

    // Scan state: position, recent bases and the best window so far.
    always_comb begin
        pos_next       = pos_reg;
        recent_next    = recent_reg;
        top_score_next = top_score_reg;
        top_start_next = top_start_reg;
        top_bases_next = top_bases_reg;
        if (cmp_fire && take) begin
            top_score_next = sel_score;
            top_start_next = cand_start;
            top_bases_next = cand_bases;
        end
        if (seq_clear) begin
            pos_next       = '0;
            recent_next    = '0;
            top_score_next = '0;
            top_start_next = '0;
            top_bases_next = '0;
        end else if (base_take) begin
            pos_next    = pos_reg + POS_W'(1);
            recent_next = {s_nuc, recent_reg[BASES_W-1:NUC_W]};
        end
    end

    always_comb begin
        cmp_valid_next = cmp_valid_reg;
        cmp_took_next  = cmp_took_reg;
        cmp_last_next  = cmp_last_reg;
        if (s_fire && s_is_base) begin
            cmp_valid_next = 1'b1;
            cmp_took_next  = base_take;
            cmp_last_next  = s_tlast;
        end else if (cmp_fire) begin
            cmp_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg && !m_tready;
        m_start_next  = m_start_reg;
        m_bases_next  = m_bases_reg;
        m_score_next  = m_score_reg;
        m_status_next = m_status_reg;
        if (seq_clear) begin
            m_valid_next  = 1'b1;
            m_status_next = !pos_ge_k;
            if (!pos_ge_k) begin
                m_start_next = '0;
                m_bases_next = '0;
                m_score_next = '0;
            end else if (take) begin
                m_start_next = cand_start;
                m_bases_next = cand_bases;
                m_score_next = sel_score;
            end else begin
                m_start_next = top_start_reg;
                m_bases_next = top_bases_reg;
                m_score_next = top_score_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            recent_reg    <= '0;
            top_score_reg <= '0;
            top_start_reg <= '0;
            top_bases_reg <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_took_reg  <= 1'b0;
            cmp_last_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            recent_reg    <= recent_next;
            top_score_reg <= top_score_next;
            top_start_reg <= top_start_next;
            top_bases_reg <= top_bases_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_took_reg  <= cmp_took_next;
            cmp_last_reg  <= cmp_last_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_start_reg  <= m_start_next;
        m_bases_reg  <= m_bases_next;
        m_score_reg  <= m_score_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {(M_TDATA_W - START_W - BASES_W - SCORE_W)'(0),
                       m_score_reg, m_bases_reg, m_start_reg};

`ifndef SYNTHESIS
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_SEQUENCE_LENGTH))
        else $error("base count ran past the sequence limit");

    a_score_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        top_score_reg <= SCORE_ONE)
        else $error("best score exceeds one");

    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_clear |=> (pos_reg == '0) && (top_score_reg == '0) && m_tvalid)
        else $error("sequence state not cleared when the result was loaded");

    a_short_seq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("short sequence result carries a nonzero payload");
`endif

endmodule

// File: tb/kmer_scan_checker.sv
// ----------------------------------------------------------------------------
// kmer_scan_checker: scoreboard for the profile most probable k-mer scanner
// Watches the window length writes and both stream channels, keeps its own
// model of the profile, the partial products and the best window, and
// compares every result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kmer_scan_checker #(
    parameter int SEQ_LIMIT = 1048576
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [pkmer_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [pkmer_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [pkmer_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    output int                              mismatches,
    output int                              outstanding
);
    import pkmer_pkg::*;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [BASES_W-1:0] bases;
        logic [SCORE_W-1:0] score;
        logic               status;
    } best_window_t;

    logic [PROB_W-1:0]  profile [NUC_CODES*PP_SLOTS];
    logic [SCORE_W-1:0] partial [PP_SLOTS];
    logic [BASES_W-1:0] recent;
    int                 base_count;
    logic [SCORE_W-1:0] top_score;
    logic [START_W-1:0] top_start;
    logic [BASES_W-1:0] top_bases;
    logic [CFG_W-1:0]   window_reg;
    best_window_t       expected_best [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch in %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
        mismatches++;
    endtask

    // Score times probability, both at most 1.0, truncated back to Q1.32.
    function automatic logic [SCORE_W-1:0] scale_by_prob(input logic [SCORE_W-1:0] score,
                                                         input logic [PROB_W-1:0] prob);
        logic [SCORE_W+PROB_W-1:0] product;
        product = {{PROB_W{1'b0}}, score} * {{SCORE_W{1'b0}}, prob};
        return product[PROB_FRAC_BITS +: SCORE_W];
    endfunction

    task automatic clear_sequence();
        foreach (partial[j]) partial[j] = '0;
        recent     = '0;
        base_count = 0;
        top_score  = '0;
        top_start  = '0;
        top_bases  = '0;
    endtask

    task automatic take_base(input logic [NUC_W-1:0] nuc, input logic is_last);
        int                 k;
        logic [SCORE_W-1:0] sc;
        best_window_t       res;
        k = (window_reg == 0) ? 1 : (window_reg > PP_SLOTS) ? PP_SLOTS : int'(window_reg);
        // Bases beyond the sequence limit are dropped, but a last mark still counts.
        if (base_count < SEQ_LIMIT) begin
            for (int j = k - 1; j >= 1; j--)
                partial[j] = scale_by_prob(partial[j-1], profile[{nuc, 4'(j)}]);
            partial[0] = scale_by_prob(SCORE_ONE, profile[{nuc, 4'd0}]);
            recent = {nuc, recent[BASES_W-1:2]};
            base_count++;
            if (base_count >= k) begin
                sc = partial[k-1];
                // The first full window is always taken; ties keep the earlier one.
                if (base_count == k || sc > top_score) begin
                    top_score = sc;
                    top_start = START_W'(base_count - k);
                    top_bases = recent >> (2 * (PP_SLOTS - k));
                end
            end
        end
        if (is_last) begin
            res = '0;
            if (base_count >= k) begin
                res.start = top_start;
                res.bases = top_bases;
                res.score = top_score;
            end else begin
                res.status = 1'b1;
            end
            expected_best = {expected_best, res};
            clear_sequence();
        end
    endtask

    always @(posedge aclk) begin : watch
        best_window_t       want;
        logic [PROB_W-1:0]  prob;
        if (!aresetn) begin
            foreach (profile[i]) profile[i] = '0;
            clear_sequence();
            window_reg = WINDOW_LENGTH_RESET;
            expected_best.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_best.size() == 0) begin
                    report("unexpected result", '0, {m_tuser, m_tdata[62:0]});
                end else begin
                    want = expected_best.pop_front();
                    if (m_tuser !== want.status)
                        report("status", want.status, m_tuser);
                    if (m_tdata[0 +: START_W] !== want.start)
                        report("best_start", want.start, m_tdata[0 +: START_W]);
                    if (m_tdata[START_W +: BASES_W] !== want.bases)
                        report("best_bases", want.bases, m_tdata[START_W +: BASES_W]);
                    if (m_tdata[START_W+BASES_W +: SCORE_W] !== want.score)
                        report("best_score", want.score, m_tdata[START_W+BASES_W +: SCORE_W]);
                end
            end
            if (cfg_wr_en)
                window_reg = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                if (op_t'(s_tuser) == OP_PROFILE_WRITE) begin
                    prob = s_tdata[6 +: PROB_W];
                    if (prob > PROB_ONE) prob = PROB_ONE;
                    profile[s_tdata[0 +: NUC_W+COL_W] >> NUC_W | s_tdata[1:0] << COL_W] = prob;
                end else begin
                    take_base(s_tdata[0 +: NUC_W], s_tlast);
                end
            end
        end
        outstanding <= expected_best.size();
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for profile_most_probable_kmer_scan_unit
// Loads a full profile, runs a short directed set of sequences and then
// random phases of window lengths, profile updates and base streams with
// random gaps on both channels. Checking is done by kmer_scan_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pkmer_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 8;
    localparam int IDLE_PCT       = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int SEQ_LIMIT      = 256;
    localparam int TIMEOUT_CYCLES = 400000;

    localparam logic [NUC_W-1:0] BASE_A = 2'd0;
    localparam logic [NUC_W-1:0] BASE_C = 2'd1;
    localparam logic [NUC_W-1:0] BASE_G = 2'd2;
    localparam logic [NUC_W-1:0] BASE_T = 2'd3;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int mismatches;
    int outstanding;
    int items_sent = 0;
    int keff       = 1;
    bit steady     = 1'b0;

    profile_most_probable_kmer_scan_unit #(
        .MAX_SEQUENCE_LENGTH(SEQ_LIMIT)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    kmer_scan_checker #(
        .SEQ_LIMIT(SEQ_LIMIT)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Mostly values that keep long products distinguishable, plus zero, one
    // and values above one that the block must saturate.
    function automatic logic [PROB_W-1:0] pick_probability();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return PROB_ONE;
        if (roll < 26)
            return PROB_W'($urandom_range(int'(PROB_ONE) + 1, (1 << PROB_W) - 1));
        return PROB_W'($urandom_range(40000, int'(PROB_ONE) - 1));
    endfunction

    task automatic send_item(input op_t op, input logic [NUC_W-1:0] nuc,
                             input logic [COL_W-1:0] col, input logic [PROB_W-1:0] prob,
                             input logic is_last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= is_last;
        s_tdata  <= {1'b0, prob, col, nuc};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic write_profile(input logic [NUC_W-1:0] nuc, input logic [COL_W-1:0] col,
                                 input logic [PROB_W-1:0] prob);
        send_item(OP_PROFILE_WRITE, nuc, col, prob, 1'($urandom_range(0, 1)));
    endtask

    // Column and probability are don't-care on a base and get random bits.
    task automatic send_base(input logic [NUC_W-1:0] nuc, input logic is_last);
        send_item(OP_BASE, nuc, COL_W'($urandom_range(0, 15)), PROB_W'($urandom), is_last);
    endtask

    task automatic send_sequence(input int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4)
                write_profile(NUC_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 15)),
                              pick_probability());
            send_base(NUC_W'($urandom_range(0, 3)), i == len - 1);
        end
    endtask

    // Holds the input until every predicted result has been taken, then lets
    // the compare stage settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keff = (value == 0) ? 1 : (value > PP_SLOTS) ? PP_SLOTS : int'(value);
    endtask

    initial begin
        int len;
        int nseq;
        int phase;
        int target;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every profile entry is written before the first base is scanned.
        for (int n = 0; n < NUC_CODES; n++)
            for (int c = 0; c < PP_SLOTS; c++)
                write_profile(NUC_W'(n), COL_W'(c), pick_probability());
        write_profile(BASE_T, 4'd15, {PROB_W{1'b1}});
        write_profile(BASE_G, 4'd15, PROB_ONE + 1'b1);
        write_profile(BASE_C, 4'd15, PROB_ONE);
        write_profile(BASE_A, 4'd15, '0);

        // Sequence shorter than the window, then one exactly as long.
        set_window(5'd3);
        send_base(BASE_A, 1'b0);
        send_base(BASE_C, 1'b1);
        send_base(BASE_G, 1'b0);
        send_base(BASE_T, 1'b0);
        send_base(BASE_A, 1'b1);

        // Zero acts as a window of one; equal scores keep the earliest start.
        set_window(5'd0);
        repeat (3) send_base(BASE_C, 1'b0);
        send_base(BASE_C, 1'b1);

        // Window length changed in the middle of a sequence, with a profile
        // write carrying a last mark slipped in between the bases.
        set_window(5'd2);
        send_base(BASE_T, 1'b0);
        send_base(BASE_G, 1'b0);
        send_item(OP_PROFILE_WRITE, BASE_G, 4'd1, PROB_ONE + 17'd5, 1'b1);
        send_base(BASE_A, 1'b0);
        set_window(5'd4);
        send_base(BASE_C, 1'b0);
        send_base(BASE_A, 1'b1);

        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case (phase)
                0: set_window(5'd1);
                1: set_window(5'd16);
                2: set_window(5'd31);
                3: set_window(5'd0);
                default: begin
                    if ($urandom_range(0, 9) < 7)
                        set_window(CFG_W'($urandom_range(1, 16)));
                    else
                        set_window(CFG_W'($urandom_range(0, 31)));
                end
            endcase
            steady = (phase == 2);
            repeat ($urandom_range(0, 4))
                write_profile(NUC_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 15)),
                              pick_probability());
            nseq = $urandom_range(3, 10);
            for (int s = 0; s < nseq; s++) begin
                if (phase == 4 && s == 0)
                    len = SEQ_LIMIT + $urandom_range(1, 6);
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(1, keff);
                else
                    len = $urandom_range(keff, keff + 30);
                send_sequence(len);
            end
            phase++;
        end
        steady = 1'b0;

        drain();
        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/pkmer_pkg.sv
hdl/pkmer_cell.sv
hdl/profile_most_probable_kmer_scan_unit.sv
tb/kmer_scan_checker.sv
tb/testbench.sv
